/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/htw_pkg.sv */
// ----------------------------------------------------------------------------
// Hashed timing wheel package
// Shared constants, request and response types, arming arithmetic.
// ----------------------------------------------------------------------------
package htw_pkg;

   localparam int TIMERS  = 32;
   localparam int SLOTS   = 256;
   localparam int TICK_MS = 10;

   localparam int ID_W     = 5;
   localparam int IDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int SLOT_W   = 8;
   localparam int ROUNDS_W = 13;
   localparam int PERIOD_W = 24;
   localparam int RUNS_W   = 16;
   localparam int LAP      = SLOTS * TICK_MS;
   localparam int OFF_W    = (LAP > 1) ? $clog2(LAP) : 1;

   // The arming arithmetic relies on LAP being 5 * 2**LAP_SHIFT and TICK_MS
   // being 2 * 5. Both divisions by five use a reciprocal multiplication that
   // is exact over the operand ranges below.
   localparam int LAP_SHIFT   = 9;
   localparam int QUO_IN_W    = PERIOD_W - LAP_SHIFT;
   localparam int RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;
   localparam int RECIP_SHIFT = 18;
   localparam int QUO_W       = QUO_IN_W + RECIP_W - RECIP_SHIFT;
   localparam int HALF_W      = OFF_W - 1;
   localparam int OFF_RECIP_W = 12;
   localparam logic [OFF_RECIP_W-1:0] OFF_RECIP = 12'd3277;
   localparam int OFF_RECIP_SHIFT = 14;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // Entry record: slot, rounds, period, runs left.
   localparam int ENTRY_W = SLOT_W + ROUNDS_W + PERIOD_W + RUNS_W;

   typedef struct packed {
      logic                command;
      logic [ID_W-1:0]     timer_id;
      logic [PERIOD_W-1:0] period_ms;
      logic [RUNS_W-1:0]   run_count;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] fired_id;
      logic            finished;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [ROUNDS_W-1:0] rounds;
      logic [PERIOD_W-1:0] period;
      logic [RUNS_W-1:0]   runs_left;
   } entry_type;

   // Period clamped to at least one tick.
   function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
      return (p < PERIOD_W'(TICK_MS)) ? PERIOD_W'(TICK_MS) : p;
   endfunction

endpackage

/* hw/rtl/htw_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/hashed_timing_wheel_core.sv */
// ----------------------------------------------------------------------------
// Hashed timing wheel core
// 256-slot timing wheel holding 32 timer entries in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_ carries a command. A register request arms one timer
//   entry with a period in milliseconds and a run count (zero repeats for
//   ever); it produces no response. A tick request visits the current slot
//   and returns one response on rsp_ for each entry that fires, in ascending
//   id order, with last set on the final one of that tick.
//   Arming splits the period into rounds and a slot offset by reciprocal
//   multiplication in the quotient, remainder and write-back steps, and a
//   register request holds the input not ready until write-back is done.
//   A tick walks the entry RAM one entry at a time (read, evaluate, emit),
//   runs the arming steps again to re-arm each entry that fires, and adds
//   one more emit pass when the final entry fires behind a held one. The
//   registered RAM read and the arming steps set the length of a tick, and
//   only one request is in flight.
//   While a response waits in the output register the scan holds, so a
//   stalled receiver simply stretches the tick. Reset clears the valid bits
//   and the wheel position at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_timing_wheel_core
   import htw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Arming steps: quotient, remainder, then offset and write-back.
   localparam logic [1:0] DIV_QUO   = 2'd0;
   localparam logic [1:0] DIV_REM   = 2'd1;
   localparam logic [1:0] DIV_WRITE = 2'd2;

   state_type            state_ff;
   logic [TIMERS-1:0]    valid_ff;
   logic [SLOT_W-1:0]    pos_ff;
   logic                 is_tick_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 hit_ff;
   entry_type            ent_ff;
   logic                 fin_ff;
   logic                 pend_ff;
   logic [IDX_W-1:0]     pend_id_ff;
   logic                 pend_fin_ff;
   // Arming: rounds are the period over LAP, the offset is the rest over TICK_MS.
   logic [QUO_W-1:0]     quo_ff;
   logic [PERIOD_W-1:0]  rem_ff;
   logic [1:0]           step_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 wr_en;
   entry_type            wr_data;
   entry_type            rd_data;
   logic [IDX_W-1:0]     rd_addr;

   htw_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMERS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [QUO_IN_W+RECIP_W-1:0]  quo_prod;
   logic [QUO_W-1:0]             quo_calc;
   logic [PERIOD_W-1:0]          lap_mult;
   logic [PERIOD_W-1:0]          rem_calc;
   logic [HALF_W+OFF_RECIP_W-1:0] off_prod;
   logic [SLOT_W-1:0]            off_slot;
   logic                         rsp_free;
   logic [RUNS_W-1:0]            runs_dec;
   logic                         fire_fin;
   logic                         scan_done;
   logic                         emit_send;
   logic                         pend_in;
   rsp_type                      emit_rsp;

   always_comb begin
      // Period over LAP: drop the power-of-two factor, then divide by five.
      quo_prod = (QUO_IN_W+RECIP_W)'(ent_ff.period[PERIOD_W-1:LAP_SHIFT])
                 * (QUO_IN_W+RECIP_W)'(RECIP5);
      quo_calc = quo_prod[QUO_IN_W+RECIP_W-1:RECIP_SHIFT];
      // LAP is four plus one times 2**LAP_SHIFT.
      lap_mult = (PERIOD_W'(quo_ff) << (LAP_SHIFT + 2)) + (PERIOD_W'(quo_ff) << LAP_SHIFT);
      rem_calc = ent_ff.period - lap_mult;
      // Remainder over TICK_MS: halve, then divide by five.
      off_prod = (HALF_W+OFF_RECIP_W)'(rem_ff[OFF_W-1:1])
                 * (HALF_W+OFF_RECIP_W)'(OFF_RECIP);
      off_slot = off_prod[SLOT_W+OFF_RECIP_SHIFT-1:OFF_RECIP_SHIFT];
      rsp_free = !rsp_valid_ff || rsp_ready;
      runs_dec = (rd_data.runs_left != '0) ? rd_data.runs_left - 1'b1 : rd_data.runs_left;
      fire_fin = (rd_data.runs_left == RUNS_W'(1));
      // Response handling: a firing is held until it is known whether it is the last.
      scan_done = (idx_ff == IDX_W'(TIMERS - 1));
      emit_send = (state_ff == ST_EMIT) && rsp_free
                  && (pend_ff ? (hit_ff || scan_done) : (hit_ff && scan_done));
      pend_in   = hit_ff ? (pend_ff || !scan_done) : (pend_ff && !scan_done);
      emit_rsp.fired_id = ID_W'(pend_ff ? pend_id_ff : idx_ff);
      emit_rsp.finished = pend_ff ? pend_fin_ff : fin_ff;
      emit_rsp.last     = scan_done && !(hit_ff && pend_ff);
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_data  = ent_ff;
      if (state_ff == ST_DIV && step_ff == DIV_WRITE) begin
         wr_en          = !fin_ff;
         wr_data.slot   = pos_ff + off_slot;
         // A 24-bit period never needs more rounds than the field holds.
         wr_data.rounds = quo_ff;
      end else if (state_ff == ST_EVAL && rd_data.rounds != '0 && valid_ff[idx_ff]
                   && rd_data.slot == pos_ff) begin
         wr_en          = 1'b1;
         wr_data        = rd_data;
         wr_data.rounds = rd_data.rounds - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (emit_send) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= emit_rsp;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  is_tick_ff <= (req_data.command == CMD_TICK);
                  pend_ff    <= 1'b0;
                  if (req_data.command == CMD_TICK) begin
                     idx_ff   <= '0;
                     state_ff <= ST_READ;
                  end else if (32'(req_data.timer_id) < TIMERS) begin
                     idx_ff            <= IDX_W'(req_data.timer_id);
                     ent_ff.period     <= clamp_period(req_data.period_ms);
                     ent_ff.runs_left  <= req_data.run_count;
                     fin_ff            <= 1'b0;
                     valid_ff[IDX_W'(req_data.timer_id)] <= 1'b1;
                     step_ff           <= DIV_QUO;
                     state_ff          <= ST_DIV;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (valid_ff[idx_ff] && rd_data.slot == pos_ff && rd_data.rounds == '0) begin
                  // Entry fires: count down the runs, re-arm or free.
                  ent_ff  <= {rd_data.slot, rd_data.rounds, rd_data.period, runs_dec};
                  fin_ff  <= fire_fin;
                  if (fire_fin) begin
                     valid_ff[idx_ff] <= 1'b0;
                  end
                  hit_ff   <= 1'b1;
                  step_ff  <= DIV_QUO;
                  state_ff <= ST_DIV;
               end else begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == DIV_QUO) begin
                  quo_ff <= quo_calc;
               end else if (step_ff == DIV_REM) begin
                  rem_ff <= rem_calc;
               end else begin
                  state_ff <= is_tick_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  hit_ff  <= 1'b0;
                  pend_ff <= pend_in;
                  if (hit_ff) begin
                     pend_id_ff  <= idx_ff;
                     pend_fin_ff <= fin_ff;
                  end
                  if (!scan_done) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end else if (!(hit_ff && pend_ff)) begin
                     // Final firing goes out now; otherwise one more pass sends it.
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_rsp_only_busy, clock, reset,
      rsp_valid && !$past(rsp_valid), !$past(req_ready), "response raised while idle")
   `ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")
   `ASSERT_IMPL(a_no_accept_busy, clock, reset,
      state_ff != ST_IDLE, !req_ready, "request taken while busy")

endmodule
